FILE: design/awde_pkg.sv
// Shared constants, types and helpers of the adaptive-width delta encoder.
package awde_pkg;

    // Fixed geometry
    localparam int WORD_BITS       = 32;
    localparam int OFS_BITS        = $clog2(WORD_BITS);
    localparam int NUM_LEVELS      = 7;
    localparam int LEVEL_BITS      = 3;
    localparam int WIDTH_BITS      = 5;
    localparam int MAX_WORDS       = 4;
    localparam int CNT_BITS        = 3;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [LEVEL_BITS-1:0] START_LEVEL = 3'd2;
    localparam logic [LEVEL_BITS-1:0] TOP_LEVEL   = 3'd6;

    // Code width of every level
    typedef logic [NUM_LEVELS-1:0][WIDTH_BITS-1:0] t_widths;

    localparam t_widths WIDTH_RESET = {5'd31, 5'd16, 5'd11, 5'd6, 5'd3, 5'd2, 5'd1};

    // Sequencer to packer
    typedef struct packed {
        logic start;    // new sample begins, clear per-sample word count
        logic first;    // drop any unfinished packed bits
        logic shift;    // take bit_in this cycle
        logic bit_in;
        logic flush;    // zero padding of the last partial word
        logic finish;   // release the held word
        logic last;     // word stream ends with this sample
    } t_pack_cmd;

    // Packer to sequencer
    typedef struct packed {
        logic ack;       // command taken this cycle
        logic ofs_zero;  // no bits waiting in the partial word
    } t_pack_sts;

    // Width of a level; a zero register acts as width one
    function automatic logic [WIDTH_BITS-1:0] eff_width(input t_widths ws,
                                                        input logic [LEVEL_BITS-1:0] lvl);
        logic [WIDTH_BITS-1:0] w;
        w = ws[lvl];
        return (w == '0) ? WIDTH_BITS'(1) : w;
    endfunction

endpackage

FILE: design/awde_in_if.sv
// Sample input channel: valid/ready handshake with sample and framing flags.
interface awde_in_if #(
    parameter int SAMPLE_BITS = awde_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   first_sample;
    logic                   last_sample;

    modport source (output valid, output sample, output first_sample,
                    output last_sample, input ready);
    modport sink   (input valid, input sample, input first_sample,
                    input last_sample, output ready);
endinterface

FILE: design/awde_out_if.sv
// Packed word output channel: valid/ready handshake with word and end flag.
interface awde_out_if;
    logic                           valid;
    logic                           ready;
    logic [awde_pkg::WORD_BITS-1:0] packed_word;
    logic                           final_word;

    modport source (output valid, output packed_word, output final_word, input ready);
    modport sink   (input valid, input packed_word, input final_word, output ready);
endinterface

FILE: design/awde_cfg_regs.sv
// Level width register bank with write decode and reset values.
module awde_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [awde_pkg::LEVEL_BITS-1:0]     i_cfg_idx,
    input  logic [awde_pkg::WIDTH_BITS-1:0]     i_cfg_data,
    output awde_pkg::t_widths                   o_widths
);

    awde_pkg::t_widths r_widths;

    // Indexes beyond the last level are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widths <= awde_pkg::WIDTH_RESET;
        end else begin
            for (int i = 0; i < awde_pkg::NUM_LEVELS; i++) begin
                if (i_cfg_we && (i_cfg_idx == awde_pkg::LEVEL_BITS'(i))) begin
                    r_widths[i] <= i_cfg_data;
                end
            end
        end
    end

    assign o_widths = r_widths;

endmodule

FILE: design/awde_packer.sv
// Bit-serial word packer: shift-in accumulator, held word and output register.
module awde_packer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  awde_pkg::t_pack_cmd   i_cmd,
    output awde_pkg::t_pack_sts   o_sts,
    awde_out_if.source            o_out
);

    localparam int WB = awde_pkg::WORD_BITS;
    localparam int OB = awde_pkg::OFS_BITS;
    localparam int CB = awde_pkg::CNT_BITS;

    logic [WB-1:0] r_acc;
    logic [OB-1:0] r_ofs;
    logic [CB-1:0] r_cnt;
    logic [WB-1:0] r_pend;
    logic          r_pend_v;
    logic          r_flush_drop;
    logic [WB-1:0] r_out_word;
    logic          r_out_fin;
    logic          r_out_v;

    logic [WB-1:0] word;
    logic          out_free;
    logic          fill;
    logic          keep;
    logic          push_mid;
    logic          push_end;
    logic          stall;

    // Bits enter at the top, so the earliest bit ends up in bit 0
    assign word     = {i_cmd.bit_in, r_acc[WB-1:1]};
    assign out_free = !r_out_v || o_out.ready;
    assign fill     = i_cmd.shift && (r_ofs == '1);
    assign keep     = fill && (r_cnt < CB'(awde_pkg::MAX_WORDS));
    // A held word moves out once the next one fills or the sample ends
    assign push_mid = keep && r_pend_v;
    assign push_end = i_cmd.finish && r_pend_v;
    assign stall    = (push_mid || push_end) && !out_free;

    assign o_sts.ack      = !stall;
    assign o_sts.ofs_zero = (r_ofs == '0);

    // Accumulator, offset and held word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs        <= '0;
            r_cnt        <= '0;
            r_pend_v     <= 1'b0;
            r_flush_drop <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_cnt        <= '0;
                r_flush_drop <= 1'b0;
                if (i_cmd.first) begin
                    r_ofs <= '0;
                end
            end
            if (i_cmd.shift && !stall) begin
                r_acc <= word;
                r_ofs <= r_ofs + OB'(1);
                if (keep) begin
                    r_pend   <= word;
                    r_pend_v <= 1'b1;
                    r_cnt    <= r_cnt + CB'(1);
                end else if (fill && i_cmd.flush) begin
                    r_flush_drop <= 1'b1;
                end
            end
            if (i_cmd.finish && !stall) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if ((push_mid || push_end) && out_free) begin
                r_out_v    <= 1'b1;
                r_out_word <= r_pend;
                r_out_fin  <= push_end && i_cmd.last && !r_flush_drop;
            end
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.packed_word = r_out_word;
    assign o_out.final_word  = r_out_fin;

    // Never more than the allowed words per sample
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CB'(awde_pkg::MAX_WORDS))
        else $error("word count past limit");

    // A finished sample leaves no held word behind
    a_pend_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !stall) |=> !r_pend_v)
        else $error("held word survived finish");

endmodule

FILE: design/adaptive_width_delta_encoder_unit.sv
// Top level of the adaptive-width delta encoder: sequencer and code serializer.
//
//  channel  dir  handshake            word contents
//  i_in     in   valid/ready          sample, first_sample, last_sample
//  o_out    out  valid/ready          packed_word, final_word
//  i_cfg    in   i_cfg_we (no stall)  i_cfg_idx selects level width, i_cfg_data
//
// A sample passes S_CALC, then for each code sent (escapes plus the delta)
// S_CHECK and S_CODE, which sends one bit per cycle while the packer
// acknowledges, taken from the delta shift register or the escape bit counter,
// then S_DONE. last_sample adds S_FLUSH to zero-pad a partial word. A new sample
// is taken only once the previous one is done. Output back-pressure stalls the
// serializer when a held word must move out (next word fills or sample ends)
// while the output register is still full. Reset is synchronous; no clearing pass.
module adaptive_width_delta_encoder_unit #(
    parameter int SAMPLE_BITS = awde_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [awde_pkg::LEVEL_BITS-1:0]   i_cfg_idx,
    input  logic [awde_pkg::WIDTH_BITS-1:0]   i_cfg_data,
    awde_in_if.sink                           i_in,
    awde_out_if.source                        o_out
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int LW = $clog2(SAMPLE_BITS + 1);
    localparam int WB = awde_pkg::WIDTH_BITS;
    localparam int VB = awde_pkg::LEVEL_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CALC  = 6'b000010,
        S_CHECK = 6'b000100,
        S_CODE  = 6'b001000,
        S_FLUSH = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                 r_state;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_first;
    logic                   r_last;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [VB-1:0]          r_level;
    logic [DW-1:0]          r_dsh;
    logic [LW-1:0]          r_len;
    logic [WB-1:0]          r_w;
    logic                   r_esc;
    logic [WB-1:0]          r_bit;

    awde_pkg::t_widths      widths;
    awde_pkg::t_pack_cmd    pack_cmd;
    awde_pkg::t_pack_sts    pack_sts;

    logic [SAMPLE_BITS-1:0] prev_eff;
    logic [DW-1:0]          delta;
    logic [SAMPLE_BITS-1:0] mag;
    logic [LW-1:0]          len;
    logic [WB-1:0]          len_ext;
    logic [WB-1:0]          w_cur;
    logic [WB-1:0]          w_below;
    logic                   code_end;

    awde_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_widths   (widths)
    );

    awde_packer u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pack_cmd),
        .o_sts   (pack_sts),
        .o_out   (o_out)
    );

    // Delta, magnitude and its bit length
    assign prev_eff = r_first ? '0 : r_prev;
    assign delta    = {1'b0, r_sample} - {1'b0, prev_eff};
    assign mag      = delta[DW-1] ? SAMPLE_BITS'(-delta) : delta[SAMPLE_BITS-1:0];

    always_comb begin
        len = '0;
        for (int i = 0; i < SAMPLE_BITS; i++) begin
            if (mag[i]) begin
                len = LW'(i + 1);
            end
        end
    end

    // Level widths; a delta fits width w when its bit length is below w
    assign len_ext  = WB'(r_len);
    assign w_cur    = awde_pkg::eff_width(widths, r_level);
    assign w_below  = awde_pkg::eff_width(widths, r_level - VB'(1));
    assign code_end = (r_bit == r_w - WB'(1));

    // Packer commands
    always_comb begin
        pack_cmd.start  = (r_state == S_CALC);
        pack_cmd.first  = r_first;
        pack_cmd.shift  = (r_state == S_CODE) || ((r_state == S_FLUSH) && !pack_sts.ofs_zero);
        pack_cmd.bit_in = (r_state == S_CODE) && (r_esc ? code_end : r_dsh[0]);
        pack_cmd.flush  = (r_state == S_FLUSH);
        pack_cmd.finish = (r_state == S_DONE);
        pack_cmd.last   = r_last;
    end

    assign i_in.ready = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_level <= awde_pkg::START_LEVEL;
            r_prev  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sample <= i_in.sample;
                        r_first  <= i_in.first_sample;
                        r_last   <= i_in.last_sample;
                        r_state  <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_prev <= r_sample;
                    r_dsh  <= delta;
                    r_len  <= len;
                    if (r_first) begin
                        r_level <= awde_pkg::START_LEVEL;
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    // escape unless the delta fits or the level is the top one
                    r_w     <= w_cur;
                    r_esc   <= !(len_ext < w_cur) && (r_level != awde_pkg::TOP_LEVEL);
                    r_bit   <= '0;
                    r_state <= S_CODE;
                end
                S_CODE: begin
                    if (pack_sts.ack) begin
                        r_bit <= r_bit + WB'(1);
                        if (!r_esc) begin
                            r_dsh <= {r_dsh[DW-1], r_dsh[DW-1:1]};
                        end
                        if (code_end) begin
                            if (r_esc) begin
                                r_level <= r_level + VB'(1);
                                r_state <= S_CHECK;
                            end else begin
                                if ((r_level != '0) && (len_ext < w_below)) begin
                                    r_level <= r_level - VB'(1);
                                end
                                r_state <= r_last ? S_FLUSH : S_DONE;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (pack_sts.ofs_zero) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (pack_sts.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= awde_pkg::TOP_LEVEL)
        else $error("level past top");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CODE) |-> ((r_w != '0) && (r_bit < r_w)))
        else $error("code bit counter out of range");

    a_esc_climb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CODE) && r_esc && code_end && pack_sts.ack)
            |=> (r_level == $past(r_level) + VB'(1)))
        else $error("escape did not raise level");

    a_top_no_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHECK) && (r_level == awde_pkg::TOP_LEVEL)) |=> !r_esc)
        else $error("escape at top level");

endmodule
